// ===== rtl/positional_list_engine_macros.svh =====
// Assertion macros shared by the list engine RTL.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising clock edge outside reset.
`define PLE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("list engine check failed");
// Next-cycle implication.
`define PLE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("list engine check failed");
`else
`define PLE_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define PLE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/ple_pkg.sv =====
package ple_pkg;

   localparam int DEFAULT_DEPTH      = 32;
   localparam int DEFAULT_DATA_WIDTH = 32;

   // Width of positions and lengths handed to the cells (DEPTH is at most 64).
   localparam int CTL_W = 7;
   localparam int POS_W = 6;

   localparam logic [2:0] MODE_CLEAR  = 3'd0;
   localparam logic [2:0] MODE_APPEND = 3'd1;
   localparam logic [2:0] MODE_INSERT = 3'd2;
   localparam logic [2:0] MODE_DELETE = 3'd3;
   localparam logic [2:0] MODE_SWAP   = 3'd4;

   typedef struct packed {
      logic [2:0]        mode;
      logic [POS_W-1:0]  position_a;
      logic [POS_W-1:0]  position_b;
      logic signed [31:0] value;
      logic              show_after;
   } req_type;

   typedef struct packed {
      logic              status;
      logic signed [31:0] element;
      logic              has_element;
      logic              last;
   } rsp_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type      op;
      logic [CTL_W-1:0] pos;
      logic [CTL_W-1:0] len;
   } cell_cmd_type;

endpackage

// ===== rtl/positional_list_engine.sv =====
// Ordered list of up to DEPTH signed words, kept in a chain of cells, one word
// per cell. An item is taken when start is high and busy is low. Clear, and an
// append without show_after, give no result; an error result is registered
// in the execute state that follows the item. A successful operation streams
// the list, first position first, one result per cycle on rsp_valid, last
// marked on the final one; an empty list streams as one result without a
// word. Results cannot be held off: each is on rsp_item for exactly the one
// cycle that rsp_valid is high. With L the list length after the operation,
// busy covers only the execute state on clear, unshown append or error, adds
// a stream of max(L,1) results on an insert, delete or shown append, and on a
// swap adds a first pass rotating the chain once to capture the two words, then
// L results. The stream rate is set by the chain rotating one position per cycle past cell 0.
`include "positional_list_engine_macros.svh"

module positional_list_engine #(
   parameter int DEPTH      = ple_pkg::DEFAULT_DEPTH,
   parameter int DATA_WIDTH = ple_pkg::DEFAULT_DATA_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ple_pkg::req_type req_item,
   output logic             rsp_valid,
   output ple_pkg::rsp_type rsp_item
);

   localparam int LEN_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CTL_W = ple_pkg::CTL_W;
   localparam logic [CTL_W-1:0] DEPTH_C = CTL_W'(DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_STREAM
   } state_type;

   state_type                    state_ff;
   ple_pkg::req_type             req_ff;
   logic [LEN_W-1:0]             length_ff;
   logic [IDX_W-1:0]             step_ff;
   logic                         swap_ff;
   logic signed [DATA_WIDTH-1:0] swap_a_ff;
   logic signed [DATA_WIDTH-1:0] swap_b_ff;
   logic                         rsp_valid_ff;
   ple_pkg::rsp_type             rsp_ff;

   // Chain wiring
   logic signed [DATA_WIDTH-1:0] cell_word [DEPTH];
   ple_pkg::cell_cmd_type        cell_cmd;
   logic signed [DATA_WIDTH-1:0] load_word;
   logic signed [DATA_WIDTH-1:0] feedback;

   // Decode helpers
   logic [CTL_W-1:0] len_c;
   logic [CTL_W-1:0] pa_c;
   logic [CTL_W-1:0] pb_c;
   logic [CTL_W-1:0] step_c;
   logic             full;
   logic             last_step;
   logic             exec_error;
   logic             hit_a;
   logic             hit_b;

   assign len_c     = CTL_W'(length_ff);
   assign pa_c      = CTL_W'(req_ff.position_a);
   assign pb_c      = CTL_W'(req_ff.position_b);
   assign step_c    = CTL_W'(step_ff);
   assign full      = len_c >= DEPTH_C;
   assign last_step = (step_c + CTL_W'(1)) == len_c;
   assign hit_a     = (step_c + CTL_W'(1)) == pa_c;
   assign hit_b     = (step_c + CTL_W'(1)) == pb_c;
   assign load_word = DATA_WIDTH'(req_ff.value);

   // Reject checks, evaluated against the length before the operation.
   always_comb begin
      unique case (req_ff.mode)
         ple_pkg::MODE_APPEND: exec_error = full;
         ple_pkg::MODE_INSERT:
            exec_error = full || pa_c == '0 || pa_c > len_c + CTL_W'(1);
         ple_pkg::MODE_DELETE: exec_error = pa_c == '0 || pa_c > len_c;
         ple_pkg::MODE_SWAP:
            exec_error = pa_c == '0 || pb_c == '0 || pa_c > len_c || pb_c > len_c;
         default: exec_error = 1'b0;
      endcase
   end

   // Word leaving cell 0 re-enters at the tail; on a swap stream substitute
   // the captured partner word at the two chosen positions.
   always_comb begin
      feedback = cell_word[0];
      if (state_ff == ST_STREAM && swap_ff) begin
         if (hit_a) feedback = swap_b_ff;
         else if (hit_b) feedback = swap_a_ff;
      end
   end

   // Command to the chain.
   always_comb begin
      cell_cmd.op  = ple_pkg::CELL_HOLD;
      cell_cmd.pos = pa_c - CTL_W'(1);
      cell_cmd.len = len_c;
      unique case (state_ff)
         ST_EXEC: begin
            if (!exec_error) begin
               unique case (req_ff.mode)
                  ple_pkg::MODE_APPEND: begin
                     cell_cmd.op  = ple_pkg::CELL_LOAD;
                     cell_cmd.pos = len_c;
                  end
                  ple_pkg::MODE_INSERT: cell_cmd.op = ple_pkg::CELL_INSERT;
                  ple_pkg::MODE_DELETE: cell_cmd.op = ple_pkg::CELL_DELETE;
                  default:              cell_cmd.op = ple_pkg::CELL_HOLD;
               endcase
            end
         end
         ST_SCAN, ST_STREAM: cell_cmd.op = ple_pkg::CELL_ROTATE;
         default:            cell_cmd.op = ple_pkg::CELL_HOLD;
      endcase
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_chain
      logic signed [DATA_WIDTH-1:0] left_word;
      logic signed [DATA_WIDTH-1:0] right_word;
      if (i == 0) begin : g_head
         assign left_word = '0;
      end else begin : g_body_l
         assign left_word = cell_word[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_word = '0;
      end else begin : g_body_r
         assign right_word = cell_word[i+1];
      end
      ple_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .INDEX      (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cell_cmd),
         .load_word  (load_word),
         .feedback   (feedback),
         .left_word  (left_word),
         .right_word (right_word),
         .word_out   (cell_word[i])
      );
   end

   // Sequencer: state, counters and the registered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         length_ff    <= '0;
         step_ff      <= '0;
         swap_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  req_ff   <= req_item;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               step_ff  <= '0;
               swap_ff  <= 1'b0;
               state_ff <= ST_IDLE;
               if (exec_error) begin
                  // Reject: one error item.
                  rsp_valid_ff        <= 1'b1;
                  rsp_ff.status       <= 1'b1;
                  rsp_ff.element      <= '0;
                  rsp_ff.has_element  <= 1'b0;
                  rsp_ff.last         <= 1'b1;
               end else begin
                  unique case (req_ff.mode)
                     ple_pkg::MODE_CLEAR: length_ff <= '0;
                     ple_pkg::MODE_APPEND: begin
                        length_ff <= length_ff + LEN_W'(1);
                        if (req_ff.show_after) state_ff <= ST_STREAM;
                     end
                     ple_pkg::MODE_INSERT: begin
                        length_ff <= length_ff + LEN_W'(1);
                        state_ff  <= ST_STREAM;
                     end
                     ple_pkg::MODE_DELETE: begin
                        length_ff <= length_ff - LEN_W'(1);
                        state_ff  <= ST_STREAM;
                     end
                     ple_pkg::MODE_SWAP: begin
                        swap_ff  <= 1'b1;
                        state_ff <= ST_SCAN;
                     end
                     default: state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_SCAN: begin
               // Capture both swap words as they pass cell 0.
               if (hit_a) swap_a_ff <= cell_word[0];
               if (hit_b) swap_b_ff <= cell_word[0];
               if (last_step) begin
                  step_ff  <= '0;
                  state_ff <= ST_STREAM;
               end else begin
                  step_ff <= step_ff + IDX_W'(1);
               end
            end
            ST_STREAM: begin
               rsp_valid_ff  <= 1'b1;
               rsp_ff.status <= 1'b0;
               if (length_ff == '0) begin
                  rsp_ff.element     <= '0;
                  rsp_ff.has_element <= 1'b0;
                  rsp_ff.last        <= 1'b1;
                  state_ff           <= ST_IDLE;
               end else begin
                  rsp_ff.element     <= 32'(feedback);
                  rsp_ff.has_element <= 1'b1;
                  rsp_ff.last        <= last_step;
                  step_ff            <= step_ff + IDX_W'(1);
                  if (last_step) state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // An accepted item always occupies the block for the following cycle.
   `PLE_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // An error result is always the only and final result, without a word.
   `PLE_ASSERT_IMP(a_error_shape, clock, reset, rsp_valid && rsp_item.status, rsp_item.last && !rsp_item.has_element)
   // More results pending means the sequencer is still streaming.
   `PLE_ASSERT_IMP(a_stream_cont, clock, reset, rsp_valid && !rsp_item.last, state_ff == ST_STREAM)
   // The list never grows beyond the chain.
   `PLE_ASSERT_IMP(a_len_bound, clock, reset, 1'b1, len_c <= DEPTH_C)

endmodule

// ===== rtl/ple_cell.sv =====
module ple_cell #(
   parameter int DATA_WIDTH = ple_pkg::DEFAULT_DATA_WIDTH,
   parameter int INDEX      = 0
) (
   input  logic                         clock,
   input  ple_pkg::cell_cmd_type        cmd,
   input  logic signed [DATA_WIDTH-1:0] load_word,
   input  logic signed [DATA_WIDTH-1:0] feedback,
   input  logic signed [DATA_WIDTH-1:0] left_word,
   input  logic signed [DATA_WIDTH-1:0] right_word,
   output logic signed [DATA_WIDTH-1:0] word_out
);

   localparam logic [ple_pkg::CTL_W-1:0] MY_IDX  = ple_pkg::CTL_W'(INDEX);
   localparam logic [ple_pkg::CTL_W-1:0] MY_NEXT = ple_pkg::CTL_W'(INDEX + 1);

   logic signed [DATA_WIDTH-1:0] word_ff;
   logic signed [DATA_WIDTH-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      unique case (cmd.op)
         ple_pkg::CELL_LOAD: begin
            if (MY_IDX == cmd.pos) word_in = load_word;
         end
         ple_pkg::CELL_INSERT: begin
            if (MY_IDX == cmd.pos) word_in = load_word;
            else if (MY_IDX > cmd.pos && MY_IDX <= cmd.len) word_in = left_word;
         end
         ple_pkg::CELL_DELETE: begin
            if (MY_IDX >= cmd.pos && MY_NEXT < cmd.len) word_in = right_word;
         end
         ple_pkg::CELL_ROTATE: begin
            if (MY_NEXT < cmd.len) word_in = right_word;
            else if (MY_NEXT == cmd.len) word_in = feedback;
         end
         default: word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_out = word_ff;

endmodule
